### sv/tccomp_pkg.sv
// ============================================================================
// tccomp_pkg: shared types and constants
// Holds the CORDIC arctangent table and the angle constants.
// ============================================================================
`default_nettype none

package tccomp_pkg;

    localparam int TAB_LEN    = 24;
    localparam int ANG_W      = 26;       // 2^-16 degree units, enough for +-360 deg
    localparam int ANG_SHIFT  = 12;
    localparam logic signed [12:0] DEG90  = 13'sd1440;
    localparam logic signed [12:0] DEG180 = 13'sd2880;
    localparam logic signed [13:0] DEG360 = 14'sd5760;
    localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
    localparam int TRIG_W = 34;           // Q2.30 plus guard bits
    localparam int VEC_W  = 68;           // projection results and growth

    typedef logic signed [ANG_W-1:0] ang_t;

    function automatic ang_t ang_tab(input int idx);
        ang_t v;
        v = '0;
        case (idx)
            0:  v = 26'sd2949120;
            1:  v = 26'sd1740967;
            2:  v = 26'sd919879;
            3:  v = 26'sd466945;
            4:  v = 26'sd234379;
            5:  v = 26'sd117304;
            6:  v = 26'sd58666;
            7:  v = 26'sd29335;
            8:  v = 26'sd14668;
            9:  v = 26'sd7334;
            10: v = 26'sd3667;
            11: v = 26'sd1833;
            12: v = 26'sd917;
            13: v = 26'sd458;
            14: v = 26'sd229;
            15: v = 26'sd115;
            16: v = 26'sd57;
            17: v = 26'sd29;
            18: v = 26'sd14;
            19: v = 26'sd7;
            20: v = 26'sd4;
            21: v = 26'sd2;
            22: v = 26'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### sv/tccomp_trig.sv
// ============================================================================
// tccomp_trig: pipelined sine and cosine
// Folds a 1/16 degree angle into +-90 degrees and runs one CORDIC rotation
// step per register stage, then rounds to Q1.15 with saturation.
// ============================================================================
`default_nettype none

module tccomp_trig #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic signed [12:0] angle,
    output logic signed [15:0]      sin_q15,
    output logic signed [15:0]      cos_q15
);
    import tccomp_pkg::*;

    localparam int N = CORDIC_STEPS;

    logic signed [TRIG_W-1:0] x_reg [0:N];
    logic signed [TRIG_W-1:0] y_reg [0:N];
    ang_t                     z_reg [0:N];
    logic                     neg_reg [0:N];

    logic signed [13:0] fold;
    logic               fold_neg;

    always_comb
    begin
        fold     = 14'(angle);
        fold_neg = 1'b0;
        if (angle > DEG90)
        begin
            fold     = 14'(angle) - 14'(DEG180);
            fold_neg = 1'b1;
        end
        else if (angle < -DEG90)
        begin
            fold     = 14'(angle) + 14'(DEG180);
            fold_neg = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= CORDIC_K;
            y_reg[0]   <= '0;
            z_reg[0]   <= ang_t'(fold) <<< ANG_SHIFT;
            neg_reg[0] <= fold_neg;
        end
    end

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_step
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (z_reg[i] >= 0)
                    begin
                        x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                        y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                        z_reg[i+1] <= z_reg[i] - ang_tab(i);
                    end
                    else
                    begin
                        x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                        y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                        z_reg[i+1] <= z_reg[i] + ang_tab(i);
                    end
                    neg_reg[i+1] <= neg_reg[i];
                end
            end
        end
    endgenerate

    logic signed [TRIG_W-1:0] xr, yr, xs, ys;

    always_comb
    begin
        xr = (x_reg[N] + TRIG_W'(16384)) >>> 15;
        yr = (y_reg[N] + TRIG_W'(16384)) >>> 15;
        xs = neg_reg[N] ? -xr : xr;
        ys = neg_reg[N] ? -yr : yr;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_q15 <= (xs > 32767) ? 16'sd32767 : (xs < -32768) ? -16'sd32768
                       : xs[15:0];
            sin_q15 <= (ys > 32767) ? 16'sd32767 : (ys < -32768) ? -16'sd32768
                       : ys[15:0];
        end
    end

endmodule

`default_nettype wire

### sv/tilt_compensated_compass_heading_core.sv
// ============================================================================
// tilt_compensated_compass_heading_core: tilt-compensated compass heading
// Projects a magnetometer sample onto the horizontal plane and returns
// atan2 of the projection plus a declination, wrapped by 360 degrees when outside +-180.
// ============================================================================
// Usage: each input word on s_axis carries field_x, field_y, field_z
// (16 bits signed each, 1/16 uT) and tilt_pitch, tilt_roll (13 bits signed,
// 1/16 degree). Each input word gives exactly one output word on m_axis
// holding compass_heading (13 bits signed, 1/16 degree).
// The datapath is one pipeline: CORDIC_STEPS+2 stages for sine and cosine,
// two product stages, one sum stage, a quadrant stage, CORDIC_STEPS vectoring
// stages and one declination/wrap stage. Throughput is one word per cycle
// while m_axis_tready does not stall the output.
// The whole pipeline advances together; when m_axis_tready is low and the
// output holds a word, every stage holds and s_axis_tready drops, so no word
// is lost or repeated. An empty output register never blocks.
// Reset clears all valid bits and loads the declination with 258 (16.125
// degrees). cfg_we writes the declination; write it only while idle.
// ============================================================================
`default_nettype none

module tilt_compensated_compass_heading_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // field_x[15:0], field_y[31:16], field_z[47:32], tilt_pitch[60:48],
    // tilt_roll[73:61], zero fill [79:74]
    input  wire logic [79:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // compass_heading[12:0], zero fill [15:13]
    output logic [15:0]      m_axis_tdata,
    input  wire logic        cfg_we,
    input  wire logic [12:0] cfg_wdata
);
    import tccomp_pkg::*;

    localparam int N   = CORDIC_STEPS;
    localparam int LAT = 2 * N + 7;

    logic en;
    logic [LAT-1:0] vld_reg;
    logic signed [12:0] decl_reg;

    assign en            = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            decl_reg <= 13'sd258;
        end
        else
        begin
            if (en)
                vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
            if (cfg_we)
                decl_reg <= cfg_wdata;
        end
    end

    // Trig stages; field values are delayed alongside by an equal run of registers.
    logic signed [15:0] sp, cp, sr, cr;

    tccomp_trig #(.CORDIC_STEPS(N)) u_pitch (
        .clk(clk), .en(en),
        .angle(s_axis_tdata[60:48]), .sin_q15(sp), .cos_q15(cp)
    );
    tccomp_trig #(.CORDIC_STEPS(N)) u_roll (
        .clk(clk), .en(en),
        .angle(s_axis_tdata[73:61]), .sin_q15(sr), .cos_q15(cr)
    );

    logic [47:0] fld_reg [0:N+1];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fld_reg[0] <= s_axis_tdata[47:0];
            for (int k = 1; k <= N + 1; k++)
                fld_reg[k] <= fld_reg[k-1];
        end
    end

    logic signed [15:0] mx, my, mz;
    assign mx = fld_reg[N+1][15:0];
    assign my = fld_reg[N+1][31:16];
    assign mz = fld_reg[N+1][47:32];

    // Product stage 1: 16x16 products.
    logic signed [31:0] mxcp_reg, mysr_reg, mzcr_reg, mycr_reg, mzsr_reg;
    logic signed [15:0] sp1_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mxcp_reg <= mx * cp;
            mysr_reg <= my * sr;
            mzcr_reg <= mz * cr;
            mycr_reg <= my * cr;
            mzsr_reg <= mz * sr;
            sp1_reg  <= sp;
        end
    end

    // Product stage 2: 32x16 products with sin(p) and partial sums.
    logic signed [47:0] bx_prod, cx_prod;
    assign bx_prod = mysr_reg * sp1_reg;
    assign cx_prod = mzcr_reg * sp1_reg;

    logic signed [VEC_W-1:0] ax_reg, bx_reg, cx_reg, hy2_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg  <= VEC_W'(mxcp_reg) <<< 15;
            bx_reg  <= VEC_W'(bx_prod);
            cx_reg  <= VEC_W'(cx_prod);
            hy2_reg <= (VEC_W'(mycr_reg) + VEC_W'(mzsr_reg)) <<< 15;
        end
    end

    // Sum stage.
    logic signed [VEC_W-1:0] hx_reg, hy_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hx_reg <= ax_reg + bx_reg - cx_reg;
            hy_reg <= hy2_reg;
        end
    end

    // Quadrant stage and vectoring pipeline.
    logic signed [VEC_W-1:0] vx_reg [0:N];
    logic signed [VEC_W-1:0] vy_reg [0:N];
    ang_t                    vz_reg [0:N];
    logic                    zero_reg [0:N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (hx_reg == 0) && (hy_reg == 0);
            if (hx_reg < 0)
            begin
                vx_reg[0] <= -hx_reg;
                vy_reg[0] <= -hy_reg;
                vz_reg[0] <= (hy_reg >= 0) ? (ang_t'(DEG180) <<< ANG_SHIFT)
                                           : -(ang_t'(DEG180) <<< ANG_SHIFT);
            end
            else
            begin
                vx_reg[0] <= hx_reg;
                vy_reg[0] <= hy_reg;
                vz_reg[0] <= '0;
            end
        end
    end

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_vec
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (vy_reg[i] < 0)
                    begin
                        vx_reg[i+1] <= vx_reg[i] - (vy_reg[i] >>> i);
                        vy_reg[i+1] <= vy_reg[i] + (vx_reg[i] >>> i);
                        vz_reg[i+1] <= vz_reg[i] - ang_tab(i);
                    end
                    else
                    begin
                        vx_reg[i+1] <= vx_reg[i] + (vy_reg[i] >>> i);
                        vy_reg[i+1] <= vy_reg[i] - (vx_reg[i] >>> i);
                        vz_reg[i+1] <= vz_reg[i] + ang_tab(i);
                    end
                    zero_reg[i+1] <= zero_reg[i];
                end
            end
        end
    endgenerate

    // Declination and symmetric wrap.
    ang_t               zr;
    logic signed [14:0] hsum;
    logic signed [14:0] hwrap;
    logic [12:0]        head_reg;

    always_comb
    begin
        zr    = (vz_reg[N] + ang_t'(2048)) >>> ANG_SHIFT;
        hsum  = (zero_reg[N] ? 15'sd0 : 15'(zr)) + 15'(decl_reg);
        hwrap = hsum;
        if (hsum > 15'(DEG180))
            hwrap = hsum - 15'(DEG360);
        else if (hsum < -15'(DEG180))
            hwrap = hsum + 15'(DEG360);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            head_reg <= hwrap[12:0];
    end

    assign m_axis_tdata = {3'b000, head_reg};

endmodule

`default_nettype wire

### bench/tilt_compensated_compass_heading_core_test.sv
// ============================================================================
// Tilt-compensated compass heading core testbench
// Drives magnetometer and tilt words into the core, predicts every heading
// with an independent fixed-point CORDIC model and checks each output word
// in order, under random gaps, back-pressure and declination changes.
// ============================================================================
`default_nettype none

module tilt_compensated_compass_heading_core_test;

    import tccomp_pkg::*;

    localparam int STEPS = 16;
    localparam int LATENCY = 2 * STEPS + 7;

    // One sensor sample as it travels on the input bus.
    typedef struct {
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        logic signed [15:0] fz;
        logic signed [12:0] pitch;
        logic signed [12:0] roll;
    } sample_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        cfg_we;
    logic [12:0] cfg_wdata;

    int errors;
    bit hold_off;
    bit recv_enable;

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // Arctangent table in 2^-16 degree units, the same angles the core uses.
    function automatic longint atan_step(input int i);
        longint t [24];
        t = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
              14668, 7334, 3667, 1833, 917, 458, 229, 115,
              57, 29, 14, 7, 4, 2, 1, 0};
        return t[i];
    endfunction

    // Sine and cosine in Q1.15 of an angle in 1/16 degree.
    task automatic sin_cos(input longint a, output longint s, output longint c);
        bit flip;
        longint x, y, z, t;
        flip = 0;
        x = 652032874;
        y = 0;
        if (a > 1440) begin a -= 2880; flip = 1; end
        else if (a < -1440) begin a += 2880; flip = 1; end
        z = a * 4096;
        for (int i = 0; i < STEPS; i++)
        begin
            if (z >= 0)
            begin
                t = x - (y >>> i); y = y + (x >>> i); x = t; z -= atan_step(i);
            end
            else
            begin
                t = x + (y >>> i); y = y - (x >>> i); x = t; z += atan_step(i);
            end
        end
        x = (x + 16384) >>> 15;
        y = (y + 16384) >>> 15;
        if (flip) begin x = -x; y = -y; end
        c = x > 32767 ? 32767 : (x < -32768 ? -32768 : x);
        s = y > 32767 ? 32767 : (y < -32768 ? -32768 : y);
    endtask

    // Vectoring CORDIC: atan2(y, x) in 1/16 degree.
    function automatic longint bearing(input longint x, input longint y);
        longint z, t;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            z = (y >= 0) ? 64'sd2880 * 4096 : -64'sd2880 * 4096;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            if (y < 0)
            begin
                t = x - (y >>> i); y = y + (x >>> i); x = t; z -= atan_step(i);
            end
            else
            begin
                t = x + (y >>> i); y = y - (x >>> i); x = t; z += atan_step(i);
            end
        end
        return (z + 2048) >>> 12;
    endfunction

    // Expected headings, oldest first, plus the declination they were
    // computed with.
    class heading_board;
        logic [12:0] pending [$];
        logic signed [12:0] declination;

        function new();
            declination = 13'sd258;
        endfunction

        task note_sample(input sample_t smp);
            longint sp, cp, sr, cr, hx, hy, h;
            longint mx, my, mz;
            mx = smp.fx;
            my = smp.fy;
            mz = smp.fz;
            sin_cos(longint'(smp.pitch), sp, cp);
            sin_cos(longint'(smp.roll), sr, cr);
            hx = mx * cp * 32768 + my * sr * sp - mz * cr * sp;
            hy = (my * cr + mz * sr) * 32768;
            h = bearing(hx, hy) + longint'(declination);
            if (h > 2880) h -= 5760;
            else if (h < -2880) h += 5760;
            pending.push_back(h[12:0]);
        endtask

        task check_heading(input logic [15:0] word);
            logic [12:0] want;
            if (pending.size() == 0)
            begin
                report_error($sformatf("unexpected heading word %h", word));
                return;
            end
            want = pending.pop_front();
            if (word[12:0] !== want)
                report_error($sformatf("compass_heading %0d, expected %0d",
                             $signed(word[12:0]), $signed(want)));
            if (word[15:13] !== 3'b000)
                report_error($sformatf("fill bits %b not zero", word[15:13]));
        endtask
    endclass

    heading_board board;

    tilt_compensated_compass_heading_core #(.CORDIC_STEPS(STEPS)) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial clk = 0;
    always #2 clk = ~clk;

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Send one word; the predictor is updated at the accepting edge. The
    // valid stays high afterwards so that a following word can go out back
    // to back; whoever pauses the sender drops it.
    task automatic send_sample(input sample_t smp);
        s_axis_tdata <= {6'b0, smp.roll, smp.pitch, smp.fz, smp.fy, smp.fx};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        board.note_sample(smp);
        @(negedge clk);
    endtask

    task automatic send_with_gap(input sample_t smp);
        int n;
        send_sample(smp);
        n = gap_length();
        if (n > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // Wait until every heading is back and the pipeline has drained.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic set_declination(input logic signed [12:0] value);
        wait_drained();
        cfg_wdata <= value;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        board.declination = value;
    endtask

    function automatic logic signed [12:0] any_angle();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return 13'($signed($urandom_range(0, 5760)) - 2880);
        if (r < 9) return 13'($urandom());
        return ($urandom_range(0, 1)) ? 13'sd2880 : -13'sd2880;
    endfunction

    function automatic logic signed [15:0] any_field();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 16'($signed($urandom_range(0, 4000)) - 2000);
        if (r < 9) return 16'($urandom());
        return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
    endfunction

    function automatic sample_t random_sample();
        sample_t smp;
        smp.fx = any_field();
        smp.fy = any_field();
        smp.fz = any_field();
        smp.pitch = any_angle();
        smp.roll = any_angle();
        if ($urandom_range(0, 19) == 0)
        begin
            // Field straight down with no tilt leaves no horizontal part.
            smp.fx = 0;
            smp.fy = 0;
            smp.pitch = 0;
            smp.roll = 0;
        end
        return smp;
    endfunction

    function automatic sample_t make_sample(input int fx, input int fy, input int fz,
                                            input int p, input int r);
        sample_t smp;
        smp.fx = 16'(fx);
        smp.fy = 16'(fy);
        smp.fz = 16'(fz);
        smp.pitch = 13'(p);
        smp.roll = 13'(r);
        return smp;
    endfunction

    // Receiver: random back-pressure, or a long hold-off when asked.
    always @(negedge clk)
    begin
        if (!recv_enable || hold_off)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 99) < 70);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_heading(m_axis_tdata);
    end

    // Stimulus. Directed corners first, then random phases with declination
    // changes in between.
    initial
    begin
        logic signed [12:0] decl_set [6];
        sample_t smp;
        errors = 0;
        board = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        hold_off = 1'b0;
        recv_enable = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        recv_enable <= 1'b1;
        @(negedge clk);

        // Directed part at the reset declination.
        send_with_gap(make_sample(0, 0, 0, 0, 0));
        send_with_gap(make_sample(0, 0, 1000, 0, 0));
        send_with_gap(make_sample(1000, 0, 0, 0, 0));
        send_with_gap(make_sample(0, 1000, 0, 0, 0));
        send_with_gap(make_sample(-1000, 0, 0, 0, 0));
        send_with_gap(make_sample(-1000, -1, 0, 0, 0));
        send_with_gap(make_sample(0, -1000, 0, 0, 0));
        send_with_gap(make_sample(32767, 32767, 32767, 2880, 2880));
        send_with_gap(make_sample(-32768, -32768, -32768, -2880, -2880));
        send_with_gap(make_sample(-32768, 32767, -32768, 1440, -1440));
        send_with_gap(make_sample(500, 700, -300, 1441, -1441));
        send_with_gap(make_sample(500, 700, -300, 4095, -4096));
        send_with_gap(make_sample(-2000, 300, 900, -4096, 4095));
        send_with_gap(make_sample(1200, -800, 400, 900, -600));
        send_with_gap(make_sample(-1, 1, -1, 1, -1));

        decl_set = '{13'sd0, 13'sd2880, -13'sd2880, 13'sd4095, -13'sd4096, -13'sd1000};
        foreach (decl_set[k])
        begin
            set_declination(decl_set[k]);
            // Heading near +-180 so the wrap is exercised both ways.
            send_with_gap(make_sample(-1000, 1, 0, 0, 0));
            send_with_gap(make_sample(-1000, -1, 0, 0, 0));
            for (int n = 0; n < 100; n++)
                send_with_gap(random_sample());
            if (k == 1)
            begin
                // Long receiver stall while the sender keeps pushing.
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (LATENCY * 3) @(negedge clk);
                        hold_off = 1'b0;
                    end
                    for (int n = 0; n < 60; n++)
                        send_sample(random_sample());
                join
            end
        end

        set_declination(13'($signed($urandom_range(0, 5760)) - 2880));
        for (int n = 0; n < 60; n++)
            send_with_gap(random_sample());

        wait_drained();
        if (errors == 0)
            $display("tilt_compensated_compass_heading_core_test passed");
        else
            $display("tilt_compensated_compass_heading_core_test failed");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2000000;
        $display("tilt_compensated_compass_heading_core_test failed");
        $finish;
    end

endmodule

`default_nettype wire
